[src/wmm_pkg.sv]
// shared constants for the sliding-window min, mean and max block
`timescale 1ns / 1ps
`default_nettype none

package wmm_pkg;

    localparam int SAMPLE_W   = 48;  // sample and min/max width
    localparam int FRAC_W     = 8;   // fraction bits of the mean
    localparam int MEAN_W     = 56;  // mean width, integer plus fraction
    localparam int WINDOW_DEF = 16;  // default ring depth
    localparam int DIV_STEP_W = 8;   // quotient bits retired per divider cycle

endpackage

`default_nettype wire

[src/wmm_ifs.sv]
// valid/ready channel interfaces for sample words and statistics words
`timescale 1ns / 1ps
`default_nettype none

interface wmm_sample_if import wmm_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_ns;

    modport source (output valid, output sample_ns, input ready);
    modport sink   (input valid, input sample_ns, output ready);

endinterface

interface wmm_stats_if import wmm_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] min_ns;
    logic [SAMPLE_W-1:0] max_ns;
    logic [MEAN_W-1:0]   mean_fix;

    modport source (output valid, output min_ns, output max_ns, output mean_fix, input ready);
    modport sink   (input valid, input min_ns, input max_ns, input mean_fix, output ready);

endinterface

`default_nettype wire

[src/window_min_mean_max_core.sv]
// top level: sliding-window min, mean and max over duration samples
// a result passes the ring scan, the divider and the output register in that order
// one sample word at a time: the next is taken once the last result is loaded into the
//   output register, later while a finished word waits on a stalled output register
// reset: asynchronous, active low; the ring reads as all zero and the write position is zero
// a finished result waits in the output register while the next sample word is taken
`timescale 1ns / 1ps
`default_nettype none

module window_min_mean_max_core import wmm_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    wmm_sample_if.sink    sample,
    wmm_stats_if.source   stats
);

    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int DVD_W = SUM_W + FRAC_W;

    typedef enum logic [2:0] {
        ST_IDLE,   // waiting for a sample word
        ST_SCAN,   // issuing one ring read per cycle
        ST_LAST,   // last read data returns
        ST_CALC,   // kick off the divider
        ST_DIV,    // divider running
        ST_DONE    // wait for a free output register
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       wpos_reg;
    logic [AW-1:0]       raddr_reg;
    logic                pend_reg;      // ring read data valid this cycle
    logic [SAMPLE_W-1:0] lo_reg;
    logic [SAMPLE_W-1:0] hi_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                out_vld_reg;
    logic [SAMPLE_W-1:0] out_min_reg;
    logic [SAMPLE_W-1:0] out_max_reg;
    logic [MEAN_W-1:0]   out_mean_reg;

    logic                accept;
    logic                rd_en;
    logic [SAMPLE_W-1:0] rd_data;
    logic                div_start;
    logic                div_done;
    logic [DVD_W-1:0]    div_dividend;
    logic [DVD_W-1:0]    div_quotient;

    // one sample at a time: the ring is written in the accept cycle, then scanned
    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign rd_en        = (state_reg == ST_SCAN);
    assign div_start    = (state_reg == ST_CALC);
    assign div_dividend = {sum_reg, {FRAC_W{1'b0}}};

    wmm_ring #(
        .WINDOW (WINDOW),
        .AW     (AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (wpos_reg),
        .wr_data (sample.sample_ns),
        .rd_en   (rd_en),
        .rd_addr (raddr_reg),
        .rd_data (rd_data)
    );

    // mean = (sum * 256) / WINDOW, truncated
    wmm_div #(
        .DIVISOR (WINDOW),
        .DVD_W   (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wpos_reg     <= '0;
            raddr_reg    <= '0;
            pend_reg     <= 1'b0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            sum_reg      <= '0;
            out_vld_reg  <= 1'b0;
            out_min_reg  <= '0;
            out_max_reg  <= '0;
            out_mean_reg <= '0;
        end
        else
        begin
            // read data lands in the cycle after the address
            pend_reg <= rd_en;

            // fold in one ring entry per cycle
            if (pend_reg)
            begin
                if (rd_data < lo_reg)
                begin
                    lo_reg <= rd_data;
                end
                if (rd_data > hi_reg)
                begin
                    hi_reg <= rd_data;
                end
                sum_reg <= sum_reg + SUM_W'(rd_data);
            end

            // output word taken downstream; in ST_DONE the reload below covers it
            if (stats.valid && stats.ready && (state_reg != ST_DONE))
            begin
                out_vld_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        wpos_reg  <= (wpos_reg == AW'(WINDOW - 1)) ? '0 : wpos_reg + 1'b1;
                        raddr_reg <= '0;
                        lo_reg    <= '1;
                        hi_reg    <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    raddr_reg <= raddr_reg + 1'b1;
                    if (raddr_reg == AW'(WINDOW - 1))
                    begin
                        state_reg <= ST_LAST;
                    end
                end
                ST_LAST:
                begin
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // load only into an empty or draining output register
                    if (!out_vld_reg || stats.ready)
                    begin
                        out_vld_reg  <= 1'b1;
                        out_min_reg  <= lo_reg;
                        out_max_reg  <= hi_reg;
                        out_mean_reg <= div_quotient[MEAN_W-1:0];
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stats.valid    = out_vld_reg;
    assign stats.min_ns   = out_min_reg;
    assign stats.max_ns   = out_max_reg;
    assign stats.mean_fix = out_mean_reg;

endmodule

`default_nettype wire

[src/wmm_ring.sv]
// sample ring memory with per-entry valid bits, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module wmm_ring import wmm_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF,
    parameter int AW     = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire logic [SAMPLE_W-1:0] wr_data,
    input  wire logic                rd_en,
    input  wire logic [AW-1:0]       rd_addr,
    output logic      [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [WINDOW-1:0]   vld_reg;
    logic                rd_vld_reg;

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // never-written entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

[src/wmm_div.sv]
// radix-256 restoring divider by a constant window depth
`timescale 1ns / 1ps
`default_nettype none

module wmm_div import wmm_pkg::*; #(
    parameter int DIVISOR = WINDOW_DEF,
    parameter int DVD_W   = 60
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int STEPS = (DVD_W + DIV_STEP_W - 1) / DIV_STEP_W;
    localparam int PAD_W = STEPS * DIV_STEP_W;
    localparam int RW    = $clog2(DIVISOR) + 2;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [PAD_W-1:0] dvd_reg, dvd_next;
    logic [PAD_W-1:0] quo_reg, quo_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // one quotient bit per inner step, partial remainder stays below twice the divisor
    always_comb
    begin
        logic q_bit;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        q_bit    = 1'b0;
        for (int i = 0; i < DIV_STEP_W; i++)
        begin
            rem_next = {rem_next[RW-2:0], dvd_next[PAD_W-1]};
            dvd_next = {dvd_next[PAD_W-2:0], 1'b0};
            q_bit    = (rem_next >= RW'(DIVISOR));
            if (q_bit)
            begin
                rem_next = rem_next - RW'(DIVISOR);
            end
            quo_next = {quo_next[PAD_W-2:0], q_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            dvd_reg  <= PAD_W'(dividend);
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= CW'(STEPS - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[DVD_W-1:0];

endmodule

`default_nettype wire

[src/wmm_checker.sv]
// port-level checks for the sliding-window statistics core, with its bind
`timescale 1ns / 1ps
`default_nettype none

module wmm_checker import wmm_pkg::*; (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [SAMPLE_W-1:0] min_ns,
    input wire logic [SAMPLE_W-1:0] max_ns,
    input wire logic [MEAN_W-1:0]   mean_fix
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_ns) && $stable(max_ns)
            && $stable(mean_fix))
        else $error("result word changed while stalled");

    // one sample in flight: ready drops right after a sample is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while another is in flight");

    // statistics are ordered
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_ns <= max_ns)
        else $error("min above max");

    // mean lies between min and max in fixed point
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mean_fix >= {min_ns, {FRAC_W{1'b0}}})
            && (mean_fix <= {max_ns, {FRAC_W{1'b0}}}))
        else $error("mean outside min/max range");

endmodule

bind window_min_mean_max_core wmm_checker u_wmm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (stats.valid),
    .out_ready (stats.ready),
    .min_ns    (stats.min_ns),
    .max_ns    (stats.max_ns),
    .mean_fix  (stats.mean_fix)
);

`default_nettype wire

[tb/tb.sv]
// testbench for the sliding-window min, mean and max block
`timescale 1ns / 1ps

module tb;
    import wmm_pkg::*;

    localparam int                  RING_DEPTH   = WINDOW_DEF;
    localparam int                  RANDOM_ITEMS = 1525;
    localparam int                  IDLE_PCT     = 23;
    localparam int                  TAIL_CYCLES  = 40;     // idle tail, longer than the time from sample to result
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = {SAMPLE_W{1'b1}};

    // one statistics word as the block reports it
    typedef struct packed {
        logic [SAMPLE_W-1:0] min_ns;
        logic [SAMPLE_W-1:0] max_ns;
        logic [MEAN_W-1:0]   mean_fix;
    } stats_word_t;

    // mirrors the sample ring and queues the statistics each sample word should produce
    class window_stats_board;
        logic [SAMPLE_W-1:0] ring [RING_DEPTH];
        int unsigned         wr_pos;
        stats_word_t         stats_q [$];
        int unsigned         mismatches;
        int unsigned         samples_seen;
        int unsigned         stats_seen;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_pos       = 0;
            mismatches   = 0;
            samples_seen = 0;
            stats_seen   = 0;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] value);
            stats_word_t exp_word;
            logic [63:0] sum;
            ring[wr_pos] = value;
            wr_pos = (wr_pos + 1 >= RING_DEPTH) ? 0 : wr_pos + 1;
            exp_word.min_ns = SAMPLE_MAX;
            exp_word.max_ns = '0;
            sum = '0;
            foreach (ring[i]) begin
                if (ring[i] < exp_word.min_ns) exp_word.min_ns = ring[i];
                if (ring[i] > exp_word.max_ns) exp_word.max_ns = ring[i];
                sum += {16'd0, ring[i]};
            end
            // truncating divide, 8 fraction bits kept
            exp_word.mean_fix = MEAN_W'((sum << FRAC_W) / 64'(RING_DEPTH));
            stats_q.push_back(exp_word);
            samples_seen++;
        endfunction

        function void check_stats(stats_word_t got);
            stats_word_t exp_word;
            stats_seen++;
            if (stats_q.size() == 0) begin
                $display("%0t stats word with nothing pending: min %h max %h mean %h",
                         $time, got.min_ns, got.max_ns, got.mean_fix);
                mismatches++;
                return;
            end
            exp_word = stats_q.pop_front();
            if (got.min_ns !== exp_word.min_ns) begin
                $display("%0t min_ns mismatch: expected %h actual %h",
                         $time, exp_word.min_ns, got.min_ns);
                mismatches++;
            end
            if (got.max_ns !== exp_word.max_ns) begin
                $display("%0t max_ns mismatch: expected %h actual %h",
                         $time, exp_word.max_ns, got.max_ns);
                mismatches++;
            end
            if (got.mean_fix !== exp_word.mean_fix) begin
                $display("%0t mean_fix mismatch: expected %h actual %h",
                         $time, exp_word.mean_fix, got.mean_fix);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return stats_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady = 1'b0;                        // high: neither side idles
    logic [SAMPLE_W-1:0] burst_base = 48'd100000;

    window_stats_board board = new();

    wmm_sample_if sample_ch ();
    wmm_stats_if  stats_ch ();

    window_min_mean_max_core #(
        .WINDOW (RING_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch.sink),
        .stats  (stats_ch.source)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // generous fixed limit, far beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("tb: FAIL");
        $finish;
    end

    // handshakes are sampled at the rising edge; both sides are driven at the falling edge,
    // so the values seen here are the ones that settled before the edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            // a result always comes after its sample was noted, so checking first is safe
            if (stats_ch.valid && stats_ch.ready)
                board.check_stats({stats_ch.min_ns, stats_ch.max_ns, stats_ch.mean_fix});
            if (sample_ch.valid && sample_ch.ready)
                board.note_sample(sample_ch.sample_ns);
        end
    end

    // result side back-pressure, idles about 23 percent of the time outside the steady stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            stats_ch.ready <= 1'b0;
        else
            stats_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // offers one sample word and returns at the falling edge after it was taken;
    // entered at a falling edge, leaves valid high so back-to-back words need no gap
    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_ns <= value;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
    endtask

    // sender holds off until every pending statistics word has come back
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
    endtask

    // duration-like values: bursts around a drifting base, wide random and small values, with extremes mixed in
    function automatic logic [SAMPLE_W-1:0] random_duration();
        logic [63:0]         wide;
        logic [SAMPLE_W-1:0] value;
        int unsigned         pick;
        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        case (pick)
            0:       value = '0;
            1:       value = SAMPLE_MAX;
            2:       value = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
            3, 4:    value = SAMPLE_W'($urandom_range(0, 1000));
            5, 6, 7, 8, 9, 10, 11:
            begin
                // new base now and then, otherwise jitter around the current one
                if ($urandom_range(0, 15) == 0) burst_base = wide[SAMPLE_W-1:0];
                value = burst_base + SAMPLE_W'($urandom_range(0, 255));
            end
            default: value = wide[SAMPLE_W-1:0];
        endcase
        return value;
    endfunction

    initial
    begin
        int unsigned n;
        rst_n               = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_ns = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // partly filled ring: reset zeros still count, so min stays zero and the mean is diluted
        push_sample('0);
        push_sample(SAMPLE_MAX);
        push_sample(48'd1);
        push_sample(48'hAAAA_AAAA_AAAA);
        push_sample(48'h5555_5555_5555);
        push_sample(48'h8000_0000_0000);
        push_sample(48'h7FFF_FFFF_FFFF);
        push_sample(48'd17);                    // sum not a multiple of the window, so the mean has a fraction part
        // fill the whole ring with the top value: largest possible mean, min equals max
        for (n = 0; n < RING_DEPTH; n++)
            push_sample(SAMPLE_MAX);
        // one zero after wrap pulls the minimum back down
        push_sample('0);
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 700 && n < 900);
            if (n == 300 || n == 1100)
                drain_results();
            push_sample(random_duration());
        end
        steady = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d sample words and %0d statistics words over a %0d entry ring",
                 board.samples_seen, board.stats_seen, RING_DEPTH);
        $display("ring filled from reset and wrapped, with random stalls on both sides");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

[window_min_mean_max_core.f]
src/wmm_pkg.sv
src/wmm_ifs.sv
src/wmm_ring.sv
src/wmm_div.sv
src/window_min_mean_max_core.sv
src/wmm_checker.sv
tb/tb.sv
